FILE: rtl/iirlp_pkg.sv
`default_nettype none

package iirlp_pkg;

  // Filter geometry.
  localparam int MAX_ORDER    = 3;
  localparam int HIST_DEPTH   = MAX_ORDER + 1;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEFF_WIDTH  = 24;
  localparam int COEFF_FRAC   = COEFF_WIDTH - 4;
  localparam int ORDER_WIDTH  = $clog2(MAX_ORDER + 1);

  // Products and the accumulator keep full precision.
  localparam int PROD_WIDTH   = COEFF_WIDTH + SAMPLE_WIDTH;
  localparam int NUM_TERMS    = 2 * MAX_ORDER + 1;
  localparam int ACC_WIDTH    = PROD_WIDTH + $clog2(NUM_TERMS);
  localparam int RND_WIDTH    = ACC_WIDTH - COEFF_FRAC;

  // Configuration port.
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = COEFF_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEFF_WIDTH-1:0]  coeff_t;
  typedef logic [ORDER_WIDTH-1:0]         order_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_FILTER_ORDER = 3'd0,
    REG_B0_COEFF     = 3'd1,
    REG_B1_COEFF     = 3'd2,
    REG_B2_COEFF     = 3'd3,
    REG_B3_COEFF     = 3'd4,
    REG_A1_COEFF     = 3'd5,
    REG_A2_COEFF     = 3'd6,
    REG_A3_COEFF     = 3'd7
  } cfg_reg_e;

  // Reset values: order two, unity pass-through (b0 = 1.0 in Q4.20).
  localparam order_t ORDER_RESET = ORDER_WIDTH'(2);
  localparam coeff_t B0_RESET    = COEFF_WIDTH'(1 << COEFF_FRAC);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/iir_lowpass_direct_form_one_unit.sv
`default_nettype none

// Channel   Handshake                Payload
// -------   ----------------------   ---------------------------------------
// input     in_valid_i / in_ready_o  sample_in_i (16b signed)
// output    out_valid_o/out_ready_i  filtered_out_o (16b signed), saturated_o
// config    cfg_we_i (no wait)       cfg_index_i (3b), cfg_wdata_i (24b)
//
// An accepted word waits in the input history register and moves on into the
// output register when the compute stage advances; a new word is accepted every
// cycle while the output is not stalled. While it sits in the input history
// register, all multiply-accumulates, rounding and saturation resolve in one
// combinational pass into the output register and the output history. Reset
// is asynchronous, active low, and clears both histories and loads the
// default coefficients. A stall on the output holds the word in the output
// register while one more word waits in the input stage; input ready drops
// only when both are full.

module iir_lowpass_direct_form_one_unit
  import iirlp_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // Sample input
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [SAMPLE_WIDTH-1:0]   sample_in_i,
  // Filtered output
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]   filtered_out_o,
  output logic                      saturated_o,
  // Configuration writes
  input  wire                       cfg_we_i,
  input  wire  [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  // Configuration registers.
  order_t  order_q;
  coeff_t  b_q [0:MAX_ORDER];
  coeff_t  a_q [1:MAX_ORDER];

  // Histories: x_hist_q[0] is the sample being filtered, y_hist_q[0] the most
  // recent output.
  sample_t x_hist_q [0:MAX_ORDER];
  sample_t y_hist_q [0:MAX_ORDER-1];

  logic    s1_valid_q;
  logic    out_valid_q;
  sample_t out_data_q;
  logic    out_sat_q;

  logic    in_fire;
  logic    s1_adv;
  order_t  ord_eff;

  logic signed [PROD_WIDTH-1:0] b_prod [0:MAX_ORDER];
  logic signed [PROD_WIDTH-1:0] a_prod [1:MAX_ORDER];
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH-1:0]  acc_rnd;
  logic signed [RND_WIDTH-1:0]  res_wide;
  sample_t                      res_d;
  logic                         sat_d;

  // Handshake. The compute stage moves forward whenever the output register
  // is empty or being emptied; the input stage refills as it drains.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // An order of zero acts as order one; the two-bit field never exceeds the
  // maximum order.
  assign ord_eff = (order_q == '0) ? ORDER_WIDTH'(1) : order_q;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
      b_q[0]  <= B0_RESET;
      for (int k = 1; k <= MAX_ORDER; k++) begin
        b_q[k] <= '0;
        a_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FILTER_ORDER: order_q <= cfg_wdata_i[ORDER_WIDTH-1:0];
        REG_B0_COEFF:     b_q[0]  <= cfg_wdata_i;
        REG_B1_COEFF:     b_q[1]  <= cfg_wdata_i;
        REG_B2_COEFF:     b_q[2]  <= cfg_wdata_i;
        REG_B3_COEFF:     b_q[3]  <= cfg_wdata_i;
        REG_A1_COEFF:     a_q[1]  <= cfg_wdata_i;
        REG_A2_COEFF:     a_q[2]  <= cfg_wdata_i;
        REG_A3_COEFF:     a_q[3]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input history shifts on every accepted word, over its full depth, so that
  // a later increase of the order sees the true older samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= MAX_ORDER; k++) begin
        x_hist_q[k] <= '0;
      end
    end else if (in_fire) begin
      x_hist_q[0] <= sample_in_i;
      for (int k = 1; k <= MAX_ORDER; k++) begin
        x_hist_q[k] <= x_hist_q[k-1];
      end
    end
  end

  // Multiply-accumulate: the products are independent and summed in one
  // full-precision accumulator. Taps above the order contribute nothing.
  always_comb begin
    acc = '0;
    for (int k = 0; k <= MAX_ORDER; k++) begin
      b_prod[k] = b_q[k] * x_hist_q[k];
      if (k <= int'(ord_eff)) begin
        acc = acc + ACC_WIDTH'(b_prod[k]);
      end
    end
    for (int k = 1; k <= MAX_ORDER; k++) begin
      a_prod[k] = a_q[k] * y_hist_q[k-1];
      if (k <= int'(ord_eff)) begin
        acc = acc - ACC_WIDTH'(a_prod[k]);
      end
    end
  end

  // Round half up (add one half, then floor), then clip to the sample range.
  always_comb begin
    acc_rnd  = acc + (ACC_WIDTH'(1) <<< (COEFF_FRAC - 1));
    res_wide = RND_WIDTH'(acc_rnd >>> COEFF_FRAC);
    if (res_wide > RND_WIDTH'(SAMPLE_MAX)) begin
      res_d = SAMPLE_MAX;
      sat_d = 1'b1;
    end else if (res_wide < RND_WIDTH'(SAMPLE_MIN)) begin
      res_d = SAMPLE_MIN;
      sat_d = 1'b1;
    end else begin
      res_d = res_wide[SAMPLE_WIDTH-1:0];
      sat_d = 1'b0;
    end
  end

  // Output history takes the rounded, clipped result when the word leaves
  // the compute stage, so the next word in the compute stage sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        y_hist_q[k] <= '0;
      end
    end else if (s1_adv) begin
      y_hist_q[0] <= res_d;
      for (int k = 1; k < MAX_ORDER; k++) begin
        y_hist_q[k] <= y_hist_q[k-1];
      end
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res_d;
      out_sat_q  <= sat_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_data_q;
  assign saturated_o    = out_sat_q;

`ifndef SYNTHESIS
  // A clipped word always carries one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (filtered_out_o == SAMPLE_MAX) || (filtered_out_o == SAMPLE_MIN))
    else $error("saturation flag set on an unclipped word");

  // The feedback tap holds exactly the word just loaded into the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (y_hist_q[0] == out_data_q))
    else $error("output history out of step with output register");

  // A word in the compute stage is never dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && out_valid_q)
    else $error("word lost during output stall");

  // With the output register empty the block always takes a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input blocked while output register empty");

  // The effective order is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_eff != '0)
    else $error("effective filter order is zero");
`endif

endmodule

`default_nettype wire

FILE: tb/iir_lowpass_direct_form_one_unit_tb.sv
`timescale 1ns / 100ps

module iir_lowpass_direct_form_one_unit_tb;
  import iirlp_pkg::*;

  // Coefficient extremes: just under +8.0 and exactly -8.0 in Q4.20.
  localparam coeff_t COEF_TOP = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam coeff_t COEF_BOT = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
  localparam coeff_t COEF_ONE = coeff_t'(1 << COEFF_FRAC);
  localparam coeff_t COEF_HALF = coeff_t'(1 << (COEFF_FRAC - 1));
  localparam coeff_t COEF_ZERO = '0;

  // Random part: a fresh filter setting for every batch of samples.
  localparam int NUM_BATCHES = 20;
  localparam int BATCH_WORDS = 51;

  // Length of the forced output stall, and how many cycles without any
  // accepted word the watchdog tolerates before it calls the run dead.
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  // Mismatch reports beyond this count are only tallied, not printed.
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    sample_t level;
    logic    clipped;
  } filt_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  sample_t    sample_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [SAMPLE_WIDTH-1:0] filtered_out;
  logic       saturated;
  logic       cfg_we = 1'b0;
  cfg_reg_e   cfg_index = REG_FILTER_ORDER;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  iir_lowpass_direct_form_one_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_in_i    (sample_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .filtered_out_o (filtered_out),
    .saturated_o    (saturated),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Filter prediction. The testbench keeps its own copy of the coefficient
  // registers and of both sample histories. Registers only change while the
  // pipeline is empty, so applying a write here at the moment it is driven
  // lines up with the block.
  // ---------------------------------------------------------------------------
  order_t  tap_order = ORDER_RESET;
  coeff_t  b_coef [HIST_DEPTH] = '{B0_RESET, COEF_ZERO, COEF_ZERO, COEF_ZERO};
  // Index zero of the feedback set is never used; y[n] is what we compute.
  coeff_t  a_coef [HIST_DEPTH] = '{COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
  sample_t x_hist [HIST_DEPTH] = '{default: '0};
  sample_t y_hist [HIST_DEPTH] = '{default: '0};

  // Shifts one sample through the histories and returns the filtered word.
  // The accumulator is exact in 64 bits: seven products of at most 2^38 each.
  function automatic filt_word_t filter_step(input sample_t x);
    filt_word_t res;
    int         taps;
    longint     acc;
    longint     rounded;
    taps = (tap_order == '0) ? 1 : int'(tap_order);
    if (taps > MAX_ORDER) taps = MAX_ORDER;
    // Both histories always shift over their full depth, even for taps that
    // the current order ignores, so a later raise of the order sees the true
    // older samples.
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    acc = 0;
    for (int k = 0; k <= taps; k++) acc += longint'(b_coef[k]) * longint'(x_hist[k]);
    for (int k = 1; k <= taps; k++) acc -= longint'(a_coef[k]) * longint'(y_hist[k]);
    // Add one half and floor: ties go toward plus infinity.
    rounded = (acc + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC;
    res.clipped = 1'b1;
    if (rounded > longint'(SAMPLE_MAX)) begin
      res.level = SAMPLE_MAX;
    end else if (rounded < longint'(SAMPLE_MIN)) begin
      res.level = SAMPLE_MIN;
    end else begin
      res.level   = sample_t'(rounded);
      res.clipped = 1'b0;
    end
    // The feedback path works on the clipped output, not the raw sum.
    y_hist[0] = res.level;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between stimulus, driver and monitor.
  // ---------------------------------------------------------------------------
  sample_t    sample_q [$];      // samples waiting to be offered
  filt_word_t filtered_q [$];    // filtered words still owed by the block
  int         words_queued = 0;
  int         words_in = 0;
  int         words_out = 0;
  int         clipped_seen = 0;
  int         settings = 0;
  int         errors = 0;
  int         stall_run = 0;
  logic       in_took = 1'b0;
  int         src_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         hold_ticket = 0;

  // ---------------------------------------------------------------------------
  // Sample driver. A word on offer stays put until the monitor has seen it
  // accepted; only then may a new word or an idle cycle follow.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid  <= 1'b1;
        sample_in <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output receiver. Random stalls at the current rate, plus a long hold-off
  // each time the stimulus hands out a new ticket. The hold is counted here so
  // that the stimulus thread is free to keep feeding samples meanwhile.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    int hold_served;
    int hold_left;
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge. An accepted output word
  // is checked against the oldest prediction; an accepted input word runs the
  // predictor. The output can never be the input of the same edge, so the
  // order of the two steps does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    filt_word_t want;
    in_took = in_valid && in_ready;
    if (out_valid && out_ready) begin
      words_out++;
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("filtered word %0d arrived with nothing expected", $signed(filtered_out));
      end else begin
        want = filtered_q.pop_front();
        if (filtered_out !== want.level) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("filtered_out: expected %0d, got %0d", want.level, $signed(filtered_out));
        end
        if (saturated !== want.clipped) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("saturated: expected %0b, got %0b", want.clipped, saturated);
        end
      end
    end
    if (in_took) begin
      want = filter_step(sample_in);
      if (want.clipped) clipped_seen++;
      filtered_q.push_back(want);
      words_in++;
    end
    if (in_took || (out_valid && out_ready)) stall_run = 0;
    else stall_run++;
  end

  // Watchdog: a long run of cycles with no word moving in either direction
  // means the block has hung.
  initial begin
    while (stall_run < STALL_LIMIT) @(negedge clk_i);
    $display("iir_lowpass_direct_form_one_unit_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // One register write, driven at the falling edge and mirrored into the
  // predictor right away.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_WIDTH-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FILTER_ORDER) tap_order = order_t'(val);
    else if (idx <= REG_B3_COEFF) b_coef[idx - REG_B0_COEFF] = coeff_t'(val);
    else a_coef[idx - REG_B3_COEFF] = coeff_t'(val);
  endtask

  // Writes the whole register set, order first. Called only when idle.
  task automatic program_filter(input order_t ord, input coeff_t b0, input coeff_t b1,
                                input coeff_t b2, input coeff_t b3, input coeff_t a1,
                                input coeff_t a2, input coeff_t a3);
    logic [CFG_DATA_WIDTH-1:0] vals [8];
    vals = '{CFG_DATA_WIDTH'(ord), b0, b1, b2, b3, a1, a2, a3};
    for (int i = REG_FILTER_ORDER; i <= REG_A3_COEFF; i++) write_reg(cfg_reg_e'(i), vals[i]);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings++;
    @(posedge clk_i);
  endtask

  task automatic queue_sample(input sample_t s);
    sample_q.push_back(s);
    words_queued++;
  endtask

  // Waits until every queued sample went in and every filtered word came out.
  task automatic drain();
    @(negedge clk_i);
    while (words_in != words_queued || filtered_q.size() != 0) @(negedge clk_i);
  endtask

  // Sample mix: rail values, small values near zero, and full-range noise.
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return sample_t'(-1);
      3, 4:    return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Coefficient mix: the rails, zero, and random values scaled down by a
  // random shift so that many settings filter without hitting the rails.
  function automatic coeff_t pick_coeff();
    coeff_t raw;
    raw = coeff_t'($urandom);
    case ($urandom_range(15))
      0:       return COEF_TOP;
      1:       return COEF_BOT;
      2:       return COEF_ZERO;
      default: return raw >>> $urandom_range(14);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    order_t ord;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: order two, unity pass-through. The samples come out
    // unchanged, which checks the reset values and both rails of the input.
    queue_sample(sample_t'(0));
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_sample(sample_t'(1));
    queue_sample(sample_t'(-1));
    queue_sample(sample_t'(16'h5555));
    queue_sample(sample_t'(16'hAAAA));
    drain();

    // Order zero behaves as order one. A two-tap average with halves lands on
    // exact ties whenever the sum of the two samples is odd, including
    // negative ones, which must round up toward plus infinity.
    program_filter(order_t'(0), COEF_HALF, COEF_HALF, COEF_ZERO, COEF_ZERO,
                   COEF_ZERO, COEF_ZERO, COEF_ZERO);
    queue_sample(sample_t'(1));
    queue_sample(sample_t'(-1));
    queue_sample(sample_t'(-2));
    queue_sample(sample_t'(3));
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    drain();

    // Coefficients at both rails with strong positive feedback: the output
    // clips high and low, and the feedback must run on the clipped value.
    // The third feedforward and feedback taps are loaded but out of use.
    program_filter(order_t'(1), COEF_TOP, COEF_BOT, COEF_ZERO, coeff_t'(24'h123456),
                   COEF_BOT, COEF_ZERO, COEF_TOP);
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_sample(sample_t'(0));
    queue_sample(sample_t'(1));
    queue_sample(sample_t'(0));
    drain();

    // Raising the order to three must pick up the samples that were shifted
    // through the deep end of both histories while those taps were unused.
    program_filter(order_t'(3), coeff_t'(1 << (COEFF_FRAC - 2)), COEF_ZERO, COEF_ZERO,
                   COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_HALF);
    queue_sample(sample_t'(100));
    queue_sample(sample_t'(200));
    queue_sample(sample_t'(300));
    queue_sample(sample_t'(400));
    queue_sample(sample_t'(-500));
    drain();

    // Random batches. The first four walk through every order value; the
    // flow control cycles through no idling, a slow sender, a slow receiver
    // and light idling on both sides. Each batch ends with the sender waiting
    // until the block has handed back every word.
    for (int batch = 0; batch < NUM_BATCHES; batch++) begin
      ord = (batch < 4) ? order_t'(batch) : order_t'($urandom_range(3));
      program_filter(ord, pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                     pick_coeff(), pick_coeff(), pick_coeff());
      case (batch % 4)
        0:       begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin src_idle_pct = 75; rx_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin src_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      for (int n = 0; n < BATCH_WORDS; n++) queue_sample(pick_sample());
      // In a few batches the receiver blocks for a long while as the sender
      // keeps pushing, so the output and input stages both fill and input
      // ready has to drop.
      if (batch % 8 == 4) hold_ticket++;
      drain();
    end

    // Keep the monitor sampling a little longer to catch any stray word.
    repeat (8) @(posedge clk_i);

    $display("Checked %0d filtered words against %0d samples over %0d filter settings.",
             words_out, words_in, settings);
    $display("%0d outputs clipped; all four order values and coefficient rails applied.",
             clipped_seen);
    if (errors == 0) begin
      $display("iir_lowpass_direct_form_one_unit_tb passed");
    end else begin
      $display("iir_lowpass_direct_form_one_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: iir_lowpass_direct_form_one_unit.f
rtl/iirlp_pkg.sv
rtl/iir_lowpass_direct_form_one_unit.sv
tb/iir_lowpass_direct_form_one_unit_tb.sv
